// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the sequence validator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/rsv_pkg.sv =====
// Types and constants of the RTP sequence validator.
`default_nettype none

package rsv_pkg;

   localparam int unsigned SEQ_WIDTH       = 16;
   localparam int unsigned COUNT_WIDTH     = 32;
   localparam int unsigned PROB_WIDTH      = 4;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam int unsigned QUEUE_DEPTH     = 2;
   localparam int unsigned QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // Request command codes
   localparam logic CMD_PACKET  = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_SEQUENTIAL = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_DROPOUT    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_MISORDER   = 2'd2;

   // 17-bit sequence space constants
   localparam logic [SEQ_WIDTH:0] SEQ_MOD      = 17'h10000;
   localparam logic [SEQ_WIDTH:0] NO_MATCH_SEQ = 17'h10001;

   typedef enum logic {
      OP_PACKET,
      OP_RESTART
   } op_kind_type;

   typedef struct packed {
      op_kind_type          kind;
      logic [SEQ_WIDTH-1:0] seq;
      logic [SEQ_WIDTH-1:0] seq_inc;
      logic [SEQ_WIDTH-1:0] seq_dec;
   } op_type;

   typedef struct packed {
      logic [PROB_WIDTH-1:0] run_in_len;
      logic [SEQ_WIDTH-1:0]  dropout_limit;
      logic [SEQ_WIDTH-1:0]  misorder_limit;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/core/rsv_front.sv =====
// Front stage: accepts request beats and decodes them into queue entries.
`default_nettype none

module rsv_front import rsv_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_cmd,
   input  wire logic [SEQ_WIDTH-1:0] req_seq_number,
   output logic                      op_valid,
   input  wire logic                 op_ready,
   output op_type                    op_item
);

   logic   valid_ff, valid_in;
   op_type item_ff, item_in;

   assign req_ready = !valid_ff || op_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (op_ready) begin
         valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         valid_in        = 1'b1;
         item_in.kind    = (req_cmd == CMD_RESTART) ? OP_RESTART : OP_PACKET;
         item_in.seq     = req_seq_number;
         item_in.seq_inc = req_seq_number + 16'd1;
         item_in.seq_dec = req_seq_number - 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign op_valid = valid_ff;
   assign op_item  = item_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rsv_queue.sv =====
// Short queue of decoded items between front and back.
`default_nettype none

module rsv_queue import rsv_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push_valid,
   output logic        push_ready,
   input  wire op_type push_item,
   output logic        pop_valid,
   input  wire logic   pop_ready,
   output op_type      pop_item
);

   op_type                     entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff, count_in;
   logic                       push, pop;

   assign push_ready = (count_ff != QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/rsv_engine.sv =====
// Back stage: source state, sequence judgment and the result register.
`default_nettype none

module rsv_engine import rsv_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cfg_type                 cfg,
   input  wire logic                    op_valid,
   output logic                         op_ready,
   input  wire op_type                  op_item,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         rsp_accepted,
   output logic                         rsp_in_probation,
   output logic [2*SEQ_WIDTH-1:0]       rsp_extended_max_seq,
   output logic [COUNT_WIDTH-1:0]       rsp_received_count,
   output logic [SEQ_WIDTH-1:0]         rsp_base_seq
);

   logic                   valid_ff, valid_in;
   logic                   ok_ff, ok_in;
   logic [SEQ_WIDTH-1:0]   highest_ff, highest_in;
   logic [SEQ_WIDTH-1:0]   first_ff, first_in;
   logic [SEQ_WIDTH:0]     pending_ff, pending_in;
   logic [SEQ_WIDTH-1:0]   wrap_ff, wrap_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [PROB_WIDTH-1:0]  prob_ff, prob_in;

   logic [SEQ_WIDTH-1:0]   eff_highest, eff_first, eff_wrap, delta;
   logic [SEQ_WIDTH:0]     eff_pending;
   logic [COUNT_WIDTH-1:0] eff_count;
   logic [PROB_WIDTH-1:0]  eff_prob, prob_dec;
   logic                   fire;

   // State only moves when the result register is free, so it doubles as the payload.
   assign op_ready = !valid_ff || rsp_ready;
   assign fire     = op_valid && op_ready;

   always_comb begin
      // Restart: set up a new source before judging the packet
      if (op_item.kind == OP_RESTART) begin
         eff_highest = op_item.seq_dec;
         eff_first   = op_item.seq;
         eff_pending = NO_MATCH_SEQ;
         eff_wrap    = '0;
         eff_count   = '0;
         eff_prob    = cfg.run_in_len;
      end else begin
         eff_highest = highest_ff;
         eff_first   = first_ff;
         eff_pending = pending_ff;
         eff_wrap    = wrap_ff;
         eff_count   = count_ff;
         eff_prob    = prob_ff;
      end

      delta      = op_item.seq - eff_highest;
      prob_dec   = eff_prob - 4'd1;
      highest_in = eff_highest;
      first_in   = eff_first;
      pending_in = eff_pending;
      wrap_in    = eff_wrap;
      count_in   = eff_count;
      prob_in    = eff_prob;
      ok_in      = 1'b0;

      if (eff_prob != '0) begin
         // Probation: next number must follow without wrap
         highest_in = op_item.seq;
         if ({1'b0, op_item.seq} == {1'b0, eff_highest} + 17'd1) begin
            prob_in = prob_dec;
            if (prob_dec == '0) begin
               first_in   = op_item.seq;
               pending_in = NO_MATCH_SEQ;
               wrap_in    = '0;
               count_in   = 32'd1;
               ok_in      = 1'b1;
            end
         end else begin
            prob_in = cfg.run_in_len - 4'd1;
         end
      end else if (delta < cfg.dropout_limit) begin
         if (op_item.seq < eff_highest) begin
            wrap_in = eff_wrap + 16'd1;
         end
         highest_in = op_item.seq;
         count_in   = eff_count + 32'd1;
         ok_in      = 1'b1;
      end else if ({1'b0, delta} <= SEQ_MOD - {1'b0, cfg.misorder_limit}) begin
         // Large jump: resync only when the packet after the jump follows it
         if ({1'b0, op_item.seq} == eff_pending) begin
            first_in   = op_item.seq;
            highest_in = op_item.seq;
            pending_in = NO_MATCH_SEQ;
            wrap_in    = '0;
            count_in   = 32'd1;
            ok_in      = 1'b1;
         end else begin
            pending_in = {1'b0, op_item.seq_inc};
         end
      end else begin
         count_in = eff_count + 32'd1;
         ok_in    = 1'b1;
      end

      valid_in = valid_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (fire) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         ok_ff      <= 1'b0;
         highest_ff <= '0;
         first_ff   <= '0;
         pending_ff <= NO_MATCH_SEQ;
         wrap_ff    <= '0;
         count_ff   <= '0;
         prob_ff    <= '0;
      end else begin
         valid_ff <= valid_in;
         if (fire) begin
            ok_ff      <= ok_in;
            highest_ff <= highest_in;
            first_ff   <= first_in;
            pending_ff <= pending_in;
            wrap_ff    <= wrap_in;
            count_ff   <= count_in;
            prob_ff    <= prob_in;
         end
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_accepted         = ok_ff;
   assign rsp_in_probation     = (prob_ff != '0);
   assign rsp_extended_max_seq = {wrap_ff, highest_ff};
   assign rsp_received_count   = count_ff;
   assign rsp_base_seq         = first_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rtp_sequence_validator.sv =====
// Top level of the RTP sequence validator: CSRs, front, queue and engine.
//
//   channel | direction | beat moves when        | payload
//   req     | in        | req_valid & req_ready | req_cmd, req_seq_number
//   rsp     | out       | rsp_valid & rsp_ready | accepted, probation, ext seq, count, base
//   csr     | in        | csr_write_enable      | csr_index, csr_write_data
//
// One beat per cycle sustained while rsp_ready stays high; a result passes the front
// register, a queue entry and the engine state register before it can be taken.
// The engine's state update is the only loop; the queue lets the front
// keep taking beats while a result waits on rsp_ready, until the queue fills.
// Synchronous reset clears the source state and loads the CSR defaults; no clearing pass.
`default_nettype none

`include "assert_macros.svh"

module rtp_sequence_validator import rsv_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_cmd,
   input  wire logic [SEQ_WIDTH-1:0]       req_seq_number,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic                            rsp_accepted,
   output logic                            rsp_in_probation,
   output logic [2*SEQ_WIDTH-1:0]          rsp_extended_max_seq,
   output logic [COUNT_WIDTH-1:0]          rsp_received_count,
   output logic [SEQ_WIDTH-1:0]            rsp_base_seq,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   cfg_type cfg_ff, cfg_in;
   logic    front_valid, front_ready;
   op_type  front_item;
   logic    back_valid, back_ready;
   op_type  back_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MIN_SEQUENTIAL: cfg_in.run_in_len     = csr_write_data[PROB_WIDTH-1:0];
            CSR_MAX_DROPOUT:    cfg_in.dropout_limit  = csr_write_data;
            CSR_MAX_MISORDER:   cfg_in.misorder_limit = csr_write_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.run_in_len     <= 4'd2;
         cfg_ff.dropout_limit  <= 16'd3000;
         cfg_ff.misorder_limit <= 16'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rsv_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_seq_number (req_seq_number),
      .op_valid       (front_valid),
      .op_ready       (front_ready),
      .op_item        (front_item)
   );

   rsv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_item   (back_item)
   );

   rsv_engine u_engine (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .op_valid             (back_valid),
      .op_ready             (back_ready),
      .op_item              (back_item),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_accepted         (rsp_accepted),
      .rsp_in_probation     (rsp_in_probation),
      .rsp_extended_max_seq (rsp_extended_max_seq),
      .rsp_received_count   (rsp_received_count),
      .rsp_base_seq         (rsp_base_seq)
   );

   `ASSERT_SAME(a_probation_not_accepted, clock, reset, rsp_valid && rsp_in_probation,
      !rsp_accepted, "packet accepted during probation")
   `ASSERT_SAME(a_probation_zero_count, clock, reset, rsp_valid && rsp_in_probation,
      rsp_received_count == '0, "count nonzero during probation")
   `ASSERT_NEXT(a_engine_fire_shows, clock, reset, back_valid && back_ready,
      rsp_valid, "engine took an item but no result followed")

endmodule

`default_nettype wire

// ===== dv/tb_rtp_sequence_validator.sv =====
// Testbench of the RTP sequence validator: directed cases, wrap counting and random traffic.
`timescale 1ns / 1ps

module tb_rtp_sequence_validator;
   import rsv_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned PRINT_LIMIT = 40;
   localparam int unsigned PHASE_BEATS = 210;
   // Index with no register behind it; writes to it must change nothing.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic                   accepted;
      logic                   in_probation;
      logic [2*SEQ_WIDTH-1:0] extended_max_seq;
      logic [COUNT_WIDTH-1:0] received_count;
      logic [SEQ_WIDTH-1:0]   start_seq;
   } seq_status_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_cmd = CMD_PACKET;
   logic [SEQ_WIDTH-1:0]       req_seq_number = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_accepted;
   logic                       rsp_in_probation;
   logic [2*SEQ_WIDTH-1:0]     rsp_extended_max_seq;
   logic [COUNT_WIDTH-1:0]     rsp_received_count;
   logic [SEQ_WIDTH-1:0]       rsp_base_seq;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data = '0;

   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned beats_sent = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   logic [SEQ_WIDTH-1:0] seq_cursor = '0;

   // Source tracking state and register copies, at their reset values
   logic [PROB_WIDTH-1:0]  cfg_min_seq = 4'd2;
   logic [SEQ_WIDTH-1:0]   cfg_dropout_limit = 16'd3000;
   logic [SEQ_WIDTH-1:0]   cfg_misorder_limit = 16'd100;
   logic [SEQ_WIDTH-1:0]   src_highest = '0;
   logic [SEQ_WIDTH-1:0]   src_first = '0;
   logic [SEQ_WIDTH:0]     src_resync_seq = NO_MATCH_SEQ;
   logic [SEQ_WIDTH-1:0]   src_wraps = '0;
   logic [COUNT_WIDTH-1:0] src_received = '0;
   logic [PROB_WIDTH-1:0]  src_probation = '0;

   seq_status_type status_due[$];

   rtp_sequence_validator i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cmd              (req_cmd),
      .req_seq_number       (req_seq_number),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_accepted         (rsp_accepted),
      .rsp_in_probation     (rsp_in_probation),
      .rsp_extended_max_seq (rsp_extended_max_seq),
      .rsp_received_count   (rsp_received_count),
      .rsp_base_seq         (rsp_base_seq),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL rtp_sequence_validator");
         $finish;
      end
   end

   task automatic report_error(input string msg);
      begin
         if (error_count < PRINT_LIMIT)
            $display("ERROR @%0t: %s", $realtime, msg);
         error_count = error_count + 1;
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      begin
         if (got !== want)
            report_error($sformatf("%s got %0h, expected %0h", name, got, want));
      end
   endtask

   task automatic restart_source(input logic [SEQ_WIDTH-1:0] seq);
      begin
         src_first      = seq;
         src_highest    = seq;
         src_resync_seq = NO_MATCH_SEQ;
         src_wraps      = '0;
         src_received   = '0;
      end
   endtask

   // Judge one packet against the tracked source and return the status it leaves.
   task automatic track_source(input logic cmd, input logic [SEQ_WIDTH-1:0] seq,
                               output seq_status_type st);
      logic [SEQ_WIDTH-1:0] gap;
      logic                 counted;
      begin
         if (cmd == CMD_RESTART) begin
            restart_source(seq);
            src_highest   = seq - 16'd1;
            src_probation = cfg_min_seq;
         end
         gap     = seq - src_highest;
         counted = 1'b1;
         if (src_probation != '0) begin
            counted = 1'b0;
            // in-sequence test does not wrap during probation
            if ({1'b0, seq} == {1'b0, src_highest} + 17'd1) begin
               src_probation = src_probation - 4'd1;
               src_highest   = seq;
               if (src_probation == '0) begin
                  restart_source(seq);
                  counted = 1'b1;
               end
            end else begin
               src_probation = cfg_min_seq - 4'd1;
               src_highest   = seq;
            end
         end else if (gap < cfg_dropout_limit) begin
            if (seq < src_highest)
               src_wraps = src_wraps + 16'd1;
            src_highest = seq;
         end else if ({1'b0, gap} <= SEQ_MOD - {1'b0, cfg_misorder_limit}) begin
            // large jump: resync only when the packet after the last jump follows it
            if ({1'b0, seq} == src_resync_seq) begin
               restart_source(seq);
            end else begin
               src_resync_seq = {1'b0, seq + 16'd1};
               counted = 1'b0;
            end
         end
         if (counted)
            src_received = src_received + 32'd1;
         st.accepted         = counted;
         st.in_probation     = (src_probation != '0);
         st.extended_max_seq = {src_wraps, src_highest};
         st.received_count   = src_received;
         st.start_seq        = src_first;
      end
   endtask

   always @(posedge clock) begin : check_results
      seq_status_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (status_due.size() == 0) begin
               report_error("result beat with no expectation waiting");
            end else begin
               want = status_due.pop_front();
               check_field("accepted", 32'(rsp_accepted), 32'(want.accepted));
               check_field("in_probation", 32'(rsp_in_probation), 32'(want.in_probation));
               check_field("extended_max_seq", rsp_extended_max_seq, want.extended_max_seq);
               check_field("received_count", rsp_received_count, want.received_count);
               check_field("first seq", 32'(rsp_base_seq), 32'(want.start_seq));
            end
         end
         if (req_valid && req_ready) begin
            track_source(req_cmd, req_seq_number, want);
            status_due.push_back(want);
         end
      end
   end

   // Drive one request beat; valid stays high after the beat until the next call.
   task automatic send_packet(input logic cmd, input logic [SEQ_WIDTH-1:0] seq);
      begin
         @(negedge clock);
         if ($urandom_range(99) < idle_pct) begin
            req_valid <= 1'b0;
            do @(negedge clock); while ($urandom_range(99) < idle_pct);
         end
         req_valid      <= 1'b1;
         req_cmd        <= cmd;
         req_seq_number <= seq;
         do @(posedge clock); while (!req_ready);
         beats_sent = beats_sent + 1;
         seq_cursor = seq;
      end
   endtask

   // Hold the sender until every expected result has come, then let the pipe settle.
   task automatic wait_for_results;
      begin
         @(negedge clock);
         req_valid <= 1'b0;
         while (status_due.size() != 0) @(posedge clock);
         repeat (4) @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      begin
         @(negedge clock);
         csr_write_enable <= 1'b1;
         csr_index        <= index;
         csr_write_data   <= data;
         @(negedge clock);
         csr_write_enable <= 1'b0;
         case (index)
            CSR_MIN_SEQUENTIAL: cfg_min_seq = data[PROB_WIDTH-1:0];
            CSR_MAX_DROPOUT:    cfg_dropout_limit = data;
            CSR_MAX_MISORDER:   cfg_misorder_limit = data;
            default: ;
         endcase
      end
   endtask

   // Packets with no restart since reset: judged as a valid source at 0.
   task automatic test_no_restart;
      begin
         send_packet(CMD_PACKET, 16'd1);
         send_packet(CMD_PACKET, 16'd3);
         send_packet(CMD_PACKET, 16'd2);
         send_packet(CMD_PACKET, 16'd3);
         send_packet(CMD_PACKET, 16'd40000);
         send_packet(CMD_PACKET, 16'd12);
         send_packet(CMD_PACKET, 16'd40000);
         send_packet(CMD_PACKET, 16'd40001);
      end
   endtask

   task automatic test_probation;
      begin
         send_packet(CMD_RESTART, 16'd100);
         send_packet(CMD_PACKET, 16'd101);
         send_packet(CMD_RESTART, 16'd500);
         send_packet(CMD_PACKET, 16'd700);
         send_packet(CMD_PACKET, 16'd701);
         // no in-sequence match past the top of the number space
         send_packet(CMD_RESTART, 16'hFFFF);
         send_packet(CMD_PACKET, 16'd0);
         send_packet(CMD_PACKET, 16'd1);
         send_packet(CMD_RESTART, 16'd0);
      end
   endtask

   task automatic test_sequence_wrap;
      begin
         send_packet(CMD_RESTART, 16'hFFFD);
         send_packet(CMD_PACKET, 16'hFFFE);
         send_packet(CMD_PACKET, 16'd2);
         send_packet(CMD_PACKET, 16'hFFFA);
      end
   endtask

   task automatic test_register_extremes;
      begin
         send_packet(CMD_RESTART, 16'd300);
         wait_for_results();
         // upper data bits are ignored by the 4-bit register
         write_csr(CSR_MIN_SEQUENTIAL, 16'hFFF0);
         send_packet(CMD_PACKET, 16'd900);
         send_packet(CMD_RESTART, 16'd300);
         wait_for_results();
         write_csr(CSR_MAX_DROPOUT, 16'd0);
         send_packet(CMD_PACKET, 16'd301);
         send_packet(CMD_PACKET, 16'd302);
         wait_for_results();
         write_csr(CSR_MAX_MISORDER, 16'd0);
         write_csr(CSR_UNUSED, 16'hFFFF);
         send_packet(CMD_PACKET, 16'd301);
         wait_for_results();
         write_csr(CSR_MIN_SEQUENTIAL, 16'd15);
         write_csr(CSR_MAX_DROPOUT, 16'hFFFF);
         write_csr(CSR_MAX_MISORDER, 16'hFFFF);
         send_packet(CMD_RESTART, 16'd7);
         send_packet(CMD_PACKET, 16'd20);
         wait_for_results();
         write_csr(CSR_MIN_SEQUENTIAL, 16'd1);
         send_packet(CMD_RESTART, 16'd9);
         send_packet(CMD_PACKET, 16'd8);
      end
   endtask

   // Step back by two every beat so nearly every beat counts a wrap.
   task automatic test_wrap_count;
      int k;
      begin
         wait_for_results();
         idle_pct  = 0;
         stall_pct = 0;
         write_csr(CSR_MIN_SEQUENTIAL, 16'd1);
         write_csr(CSR_MAX_DROPOUT, 16'hFFFF);
         send_packet(CMD_RESTART, 16'd1000);
         for (k = 0; k < 64; k++)
            send_packet(CMD_PACKET, seq_cursor - 16'd2);
      end
   endtask

   task automatic test_random_traffic;
      int unsigned phase;
      int unsigned target;
      int unsigned pick;
      int unsigned k;
      logic [SEQ_WIDTH-1:0] seq_base;
      logic [SEQ_WIDTH-1:0] seq_hold;
      begin
         for (phase = 0; phase < 8; phase++) begin
            wait_for_results();
            case (phase % 4)
               0: begin idle_pct = 0;  stall_pct = 0;  end
               1: begin idle_pct = 53; stall_pct = 0;  end
               2: begin idle_pct = 0;  stall_pct = 53; end
               default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            pick = $urandom_range(9);
            write_csr(CSR_MIN_SEQUENTIAL,
                      (pick == 0) ? 16'd15 : (pick == 1) ? 16'd1 : 16'($urandom_range(1, 4)));
            case ($urandom_range(4))
               0: write_csr(CSR_MAX_DROPOUT, 16'd1);
               1: write_csr(CSR_MAX_DROPOUT, 16'hFFFF);
               2: write_csr(CSR_MAX_DROPOUT, 16'd3000);
               default: write_csr(CSR_MAX_DROPOUT, 16'($urandom_range(1, 65535)));
            endcase
            case ($urandom_range(4))
               0: write_csr(CSR_MAX_MISORDER, 16'd0);
               1: write_csr(CSR_MAX_MISORDER, 16'hFFFF);
               2: write_csr(CSR_MAX_MISORDER, 16'd100);
               default: write_csr(CSR_MAX_MISORDER, 16'($urandom));
            endcase
            target = beats_sent + PHASE_BEATS;
            while (beats_sent < target) begin
               pick = $urandom_range(99);
               if (pick < 4) begin
                  // new source with a full in-sequence run-in, often near the top
                  seq_base = $urandom_range(1) ? 16'($urandom_range(65515, 65535))
                                               : 16'($urandom);
                  send_packet(CMD_RESTART, seq_base);
                  for (k = 1; k < cfg_min_seq; k++)
                     send_packet(CMD_PACKET, seq_base + 16'(k));
               end else if (pick < 9) begin
                  seq_base = 16'($urandom);
                  send_packet(CMD_PACKET, seq_base);
                  if ($urandom_range(3) != 0)
                     send_packet(CMD_PACKET, seq_base + 16'd1);
               end else if (pick < 15) begin
                  seq_hold = seq_cursor;
                  send_packet(CMD_PACKET, seq_cursor - 16'($urandom_range(0, 8)));
                  seq_cursor = seq_hold;
               end else if (pick < 19) begin
                  send_packet($urandom_range(1) ? CMD_RESTART : CMD_PACKET, 16'($urandom));
               end else begin
                  send_packet(CMD_PACKET, seq_cursor +
                     (($urandom_range(9) < 8) ? 16'd1 : 16'($urandom_range(2, 60))));
               end
            end
         end
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_no_restart();
      test_probation();
      test_sequence_wrap();
      test_register_extremes();
      test_wrap_count();
      test_random_traffic();
      wait_for_results();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("PASS rtp_sequence_validator");
      else
         $display("FAIL rtp_sequence_validator");
      $finish;
   end

endmodule

// ===== rtp_sequence_validator.f =====
+incdir+rtl/core
rtl/core/rsv_pkg.sv
rtl/core/rsv_front.sv
rtl/core/rsv_queue.sv
rtl/core/rsv_engine.sv
rtl/core/rtp_sequence_validator.sv
dv/tb_rtp_sequence_validator.sv
